// File: rtl/limit_order_book_matcher_assert.svh
// Assertion macros for the limit order book matcher.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lobm assertion failed");
`define LOBM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("lobm assertion failed");
`else
`define LOBM_ASSERT(label, prop)
`define LOBM_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies.
package lobm_pkg;

    localparam int ID_BITS = 32;

    localparam logic [1:0] SIDE_BUY  = 2'd0;
    localparam logic [1:0] SIDE_SELL = 2'd1;

    typedef enum logic [1:0] {
        BOOK_HOLD,
        BOOK_DEC,
        BOOK_POP,
        BOOK_INSERT
    } t_book_op;

    typedef enum logic [2:0] {
        KIND_FILL    = 3'd0,
        KIND_RESTED  = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_FULL    = 3'd4
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_MATCH
    } t_state;

endpackage

// File: rtl/lobm_cell.sv
// One slot of a book: a resting order that trades places with its neighbors.
// Depends on lobm_pkg.
module lobm_cell #(
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lobm_pkg::t_book_op      i_op,
    input  logic                    i_is_bid,
    input  logic [QTY_BITS-1:0]     i_amt,
    input  logic [PRICE_BITS-1:0]   i_new_price,
    input  logic [QTY_BITS-1:0]     i_new_qty,
    input  logic [lobm_pkg::ID_BITS-1:0] i_new_id,
    input  logic                    i_prev_keep,
    input  logic                    i_prev_valid,
    input  logic [PRICE_BITS-1:0]   i_prev_price,
    input  logic [QTY_BITS-1:0]     i_prev_qty,
    input  logic [lobm_pkg::ID_BITS-1:0] i_prev_id,
    input  logic                    i_next_valid,
    input  logic [PRICE_BITS-1:0]   i_next_price,
    input  logic [QTY_BITS-1:0]     i_next_qty,
    input  logic [lobm_pkg::ID_BITS-1:0] i_next_id,
    output logic                    o_keep,
    output logic                    o_valid,
    output logic [PRICE_BITS-1:0]   o_price,
    output logic [QTY_BITS-1:0]     o_qty,
    output logic [lobm_pkg::ID_BITS-1:0] o_id
);
    import lobm_pkg::*;

    logic                  r_valid, n_valid;
    logic [PRICE_BITS-1:0] r_price, n_price;
    logic [QTY_BITS-1:0]   r_qty, n_qty;
    logic [ID_BITS-1:0]    r_id, n_id;

    // An entry stays ahead of a new order if its price is as good or better.
    assign o_keep = r_valid && (i_is_bid ? (r_price >= i_new_price)
                                         : (r_price <= i_new_price));

    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        n_qty   = r_qty;
        n_id    = r_id;
        case (i_op)
            BOOK_HOLD: begin
            end
            BOOK_DEC: begin
                n_qty = r_qty - i_amt;
            end
            BOOK_POP: begin
                n_valid = i_next_valid;
                n_price = i_next_price;
                n_qty   = i_next_qty;
                n_id    = i_next_id;
            end
            BOOK_INSERT: begin
                if (!o_keep) begin
                    if (i_prev_keep) begin
                        n_valid = 1'b1;
                        n_price = i_new_price;
                        n_qty   = i_new_qty;
                        n_id    = i_new_id;
                    end else begin
                        n_valid = i_prev_valid;
                        n_price = i_prev_price;
                        n_qty   = i_prev_qty;
                        n_id    = i_prev_id;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price <= n_price;
        r_qty   <= n_qty;
        r_id    <= n_id;
    end

    assign o_valid = r_valid;
    assign o_price = r_price;
    assign o_qty   = r_qty;
    assign o_id    = r_id;

endmodule

// File: rtl/lobm_book.sv
// One side of the book as a row of cells, best entry at the head.
// Depends on lobm_pkg and lobm_cell.
module lobm_book #(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lobm_pkg::t_book_op      i_op,
    input  logic                    i_is_bid,
    input  logic [QTY_BITS-1:0]     i_amt,
    input  logic [PRICE_BITS-1:0]   i_new_price,
    input  logic [QTY_BITS-1:0]     i_new_qty,
    input  logic [lobm_pkg::ID_BITS-1:0] i_new_id,
    output logic                    o_head_valid,
    output logic [PRICE_BITS-1:0]   o_head_price,
    output logic [QTY_BITS-1:0]     o_head_qty,
    output logic [lobm_pkg::ID_BITS-1:0] o_head_id,
    output logic                    o_tail_valid
);
    import lobm_pkg::*;

    logic                  w_keep  [BOOK_DEPTH];
    logic                  w_valid [BOOK_DEPTH];
    logic [PRICE_BITS-1:0] w_price [BOOK_DEPTH];
    logic [QTY_BITS-1:0]   w_qty   [BOOK_DEPTH];
    logic [ID_BITS-1:0]    w_id    [BOOK_DEPTH];

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        t_book_op              w_op;
        logic                  w_pkeep, w_pvalid, w_nvalid;
        logic [PRICE_BITS-1:0] w_pprice, w_nprice;
        logic [QTY_BITS-1:0]   w_pqty, w_nqty;
        logic [ID_BITS-1:0]    w_pid, w_nid;

        // Only the head takes a partial fill.
        assign w_op = (i_op == BOOK_DEC && g != 0) ? BOOK_HOLD : i_op;

        if (g == 0) begin : g_head
            assign w_pkeep  = 1'b1;
            assign w_pvalid = 1'b0;
            assign w_pprice = i_new_price;
            assign w_pqty   = i_new_qty;
            assign w_pid    = i_new_id;
        end else begin : g_mid
            assign w_pkeep  = w_keep[g-1];
            assign w_pvalid = w_valid[g-1];
            assign w_pprice = w_price[g-1];
            assign w_pqty   = w_qty[g-1];
            assign w_pid    = w_id[g-1];
        end

        if (g == BOOK_DEPTH - 1) begin : g_tail
            assign w_nvalid = 1'b0;
            assign w_nprice = i_new_price;
            assign w_nqty   = i_new_qty;
            assign w_nid    = i_new_id;
        end else begin : g_body
            assign w_nvalid = w_valid[g+1];
            assign w_nprice = w_price[g+1];
            assign w_nqty   = w_qty[g+1];
            assign w_nid    = w_id[g+1];
        end

        lobm_cell #(
            .PRICE_BITS (PRICE_BITS),
            .QTY_BITS   (QTY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_is_bid     (i_is_bid),
            .i_amt        (i_amt),
            .i_new_price  (i_new_price),
            .i_new_qty    (i_new_qty),
            .i_new_id     (i_new_id),
            .i_prev_keep  (w_pkeep),
            .i_prev_valid (w_pvalid),
            .i_prev_price (w_pprice),
            .i_prev_qty   (w_pqty),
            .i_prev_id    (w_pid),
            .i_next_valid (w_nvalid),
            .i_next_price (w_nprice),
            .i_next_qty   (w_nqty),
            .i_next_id    (w_nid),
            .o_keep       (w_keep[g]),
            .o_valid      (w_valid[g]),
            .o_price      (w_price[g]),
            .o_qty        (w_qty[g]),
            .o_id         (w_id[g])
        );
    end

    assign o_head_valid = w_valid[0];
    assign o_head_price = w_price[0];
    assign o_head_qty   = w_qty[0];
    assign o_head_id    = w_id[0];
    assign o_tail_valid = w_valid[BOOK_DEPTH-1];

endmodule

// File: rtl/limit_order_book_matcher.sv
// Channel  Direction  Handshake           Payload
// order    in         i_valid / o_stall   i_side, i_limit_price, i_order_qty
// result   out        o_valid / i_stall   o_kind .. o_last
//
// An order is accepted in the idle state; the matcher then gives one beat per fill
// at the head of the opposite book, then the status beat that also inserts any
// remainder into the own book in a single shift of the cells.
// Reset empties both books and sets order and trade numbers to one.
// A stalled result beat holds every step; no new order is taken until the
// status beat of the current one has been loaded into the output register.
// Depends on lobm_pkg, lobm_book and limit_order_book_matcher_assert.svh.
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_side,
    input  logic [PRICE_BITS-1:0]   i_limit_price,
    input  logic [QTY_BITS-1:0]     i_order_qty,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_kind,
    output logic [lobm_pkg::ID_BITS-1:0] o_order_number,
    output logic [lobm_pkg::ID_BITS-1:0] o_resting_number,
    output logic [lobm_pkg::ID_BITS-1:0] o_trade_number,
    output logic [PRICE_BITS-1:0]   o_fill_price,
    output logic [QTY_BITS-1:0]     o_fill_qty,
    output logic                    o_last
);
    import lobm_pkg::*;

    localparam int NFILL_W = $clog2(BOOK_DEPTH + 1);

    t_state                r_state, n_state;
    logic [1:0]            r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty, n_qty;
    logic [ID_BITS-1:0]    r_oid;
    logic [ID_BITS-1:0]    r_order_count;
    logic [ID_BITS-1:0]    r_trade_count, n_trade_count;
    logic [NFILL_W-1:0]    r_nfill, n_nfill;

    logic                  r_ov, n_ov;
    t_kind                 r_kind, n_kind;
    logic [ID_BITS-1:0]    r_rest_no, n_rest_no, r_trade_no, n_trade_no, r_ord_no, n_ord_no;
    logic [PRICE_BITS-1:0] r_fprice, n_fprice;
    logic [QTY_BITS-1:0]   r_fqty, n_fqty;
    logic                  r_last, n_last;

    t_book_op              w_bid_op, w_ask_op, w_opp_op, w_own_op;
    logic                  w_bid_hv, w_ask_hv, w_bid_tv, w_ask_tv;
    logic [PRICE_BITS-1:0] w_bid_hp, w_ask_hp, w_hp;
    logic [QTY_BITS-1:0]   w_bid_hq, w_ask_hq, w_hq, w_amt;
    logic [ID_BITS-1:0]    w_bid_hi, w_ask_hi, w_hi;
    logic                  w_hv, w_is_buy, w_cross, w_can_fill, w_own_full;
    logic                  w_accept, w_load, w_bad_side;

    assign w_accept   = i_valid && !o_stall;
    assign w_load     = !r_ov || !i_stall;
    assign w_is_buy   = (r_side == SIDE_BUY);
    assign w_bad_side = !(r_side inside {SIDE_BUY, SIDE_SELL});

    assign w_hv  = w_is_buy ? w_ask_hv : w_bid_hv;
    assign w_hp  = w_is_buy ? w_ask_hp : w_bid_hp;
    assign w_hq  = w_is_buy ? w_ask_hq : w_bid_hq;
    assign w_hi  = w_is_buy ? w_ask_hi : w_bid_hi;
    assign w_own_full = w_is_buy ? w_bid_tv : w_ask_tv;
    assign w_cross = w_is_buy ? (r_price >= w_hp) : (w_hp >= r_price);
    assign w_can_fill = (r_qty != '0) && (r_nfill < NFILL_W'(BOOK_DEPTH)) && w_hv && w_cross;
    assign w_amt = (r_qty < w_hq) ? r_qty : w_hq;

    always_comb begin
        n_state       = r_state;
        n_qty         = r_qty;
        n_trade_count = r_trade_count;
        n_nfill       = r_nfill;
        n_ov          = r_ov && i_stall;
        n_kind        = r_kind;
        n_ord_no      = r_ord_no;
        n_rest_no     = r_rest_no;
        n_trade_no    = r_trade_no;
        n_fprice      = r_fprice;
        n_fqty        = r_fqty;
        n_last        = r_last;
        w_opp_op      = BOOK_HOLD;
        w_own_op      = BOOK_HOLD;
        case (r_state)
            ST_IDLE: begin
                n_nfill = '0;
                if (w_accept) begin
                    n_state = ST_MATCH;
                    n_qty   = i_order_qty;
                end
            end
            ST_MATCH: begin
                if (w_load) begin
                    n_ov       = 1'b1;
                    n_ord_no   = r_oid;
                    n_rest_no  = '0;
                    n_trade_no = '0;
                    n_fprice   = '0;
                    n_fqty     = '0;
                    n_last     = 1'b1;
                    if (w_bad_side) begin
                        n_kind  = KIND_BAD;
                        n_state = ST_IDLE;
                    end else if (w_can_fill) begin
                        n_kind        = KIND_FILL;
                        n_last        = 1'b0;
                        n_rest_no     = w_hi;
                        n_trade_no    = r_trade_count;
                        n_fprice      = w_hp;
                        n_fqty        = w_amt;
                        n_trade_count = r_trade_count + 1'b1;
                        n_qty         = r_qty - w_amt;
                        n_nfill       = r_nfill + 1'b1;
                        w_opp_op      = (w_hq == w_amt) ? BOOK_POP : BOOK_DEC;
                    end else if (r_qty == '0) begin
                        n_kind  = KIND_DONE;
                        n_state = ST_IDLE;
                    end else if (w_own_full) begin
                        n_kind   = KIND_FULL;
                        n_fprice = r_price;
                        n_fqty   = r_qty;
                        n_state  = ST_IDLE;
                    end else begin
                        n_kind   = KIND_RESTED;
                        n_fprice = r_price;
                        n_fqty   = r_qty;
                        w_own_op = BOOK_INSERT;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_bid_op = w_is_buy ? w_own_op : w_opp_op;
    assign w_ask_op = w_is_buy ? w_opp_op : w_own_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_order_count <= ID_BITS'(1);
            r_trade_count <= ID_BITS'(1);
            r_nfill       <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_trade_count <= n_trade_count;
            r_nfill       <= n_nfill;
            r_ov          <= n_ov;
            if (w_accept) begin
                r_order_count <= r_order_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_side  <= i_side;
            r_price <= i_limit_price;
            r_oid   <= r_order_count;
        end
        r_qty      <= n_qty;
        r_kind     <= n_kind;
        r_ord_no   <= n_ord_no;
        r_rest_no  <= n_rest_no;
        r_trade_no <= n_trade_no;
        r_fprice   <= n_fprice;
        r_fqty     <= n_fqty;
        r_last     <= n_last;
    end

    lobm_book #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_bids (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_bid_op),
        .i_is_bid     (1'b1),
        .i_amt        (w_amt),
        .i_new_price  (r_price),
        .i_new_qty    (r_qty),
        .i_new_id     (r_oid),
        .o_head_valid (w_bid_hv),
        .o_head_price (w_bid_hp),
        .o_head_qty   (w_bid_hq),
        .o_head_id    (w_bid_hi),
        .o_tail_valid (w_bid_tv)
    );

    lobm_book #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_asks (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_ask_op),
        .i_is_bid     (1'b0),
        .i_amt        (w_amt),
        .i_new_price  (r_price),
        .i_new_qty    (r_qty),
        .i_new_id     (r_oid),
        .o_head_valid (w_ask_hv),
        .o_head_price (w_ask_hp),
        .o_head_qty   (w_ask_hq),
        .o_head_id    (w_ask_hi),
        .o_tail_valid (w_ask_tv)
    );

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_ov;
    assign o_kind           = r_kind;
    assign o_order_number   = r_ord_no;
    assign o_resting_number = r_rest_no;
    assign o_trade_number   = r_trade_no;
    assign o_fill_price     = r_fprice;
    assign o_fill_qty       = r_fqty;
    assign o_last           = r_last;

`include "limit_order_book_matcher_assert.svh"

    `LOBM_ASSERT(a_fill_not_last, (r_ov && r_kind == KIND_FILL) |-> !r_last)
    `LOBM_ASSERT(a_fill_nonzero, (r_ov && r_kind == KIND_FILL) |-> (r_fqty != '0))
    `LOBM_ASSERT(a_accept_to_match, w_accept |=> (r_state == ST_MATCH))
    `LOBM_ASSERT(a_one_book_shifts, !(w_bid_op == BOOK_INSERT && w_ask_op == BOOK_INSERT))

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the limit order book matcher: orders in, fills and status out.
// Predicts results with its own model of both books. Depends on lobm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module testbench;
    import lobm_pkg::*;

    localparam int DEPTH = 32;
    localparam int PW = 16;
    localparam int QW = 20;
    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct packed {
        logic [2:0]    kind;
        logic [31:0]   order_number;
        logic [31:0]   resting_number;
        logic [31:0]   trade_number;
        logic [PW-1:0] fill_price;
        logic [QW-1:0] fill_qty;
        logic          last;
    } t_beat;

    typedef struct {
        logic [PW-1:0] price;
        logic [QW-1:0] qty;
        logic [31:0]   id;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_side = '0;
    logic [PW-1:0] i_limit_price = '0;
    logic [QW-1:0] i_order_qty = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_kind;
    logic [31:0] o_order_number, o_resting_number, o_trade_number;
    logic [PW-1:0] o_fill_price;
    logic [QW-1:0] o_fill_qty;
    logic o_last;

    limit_order_book_matcher uut (.*);

    always #4 i_clk = ~i_clk;

    t_entry bids[$];
    t_entry asks[$];
    logic [31:0] next_order_id;
    logic [31:0] next_trade_id;
    t_beat pending_beats[$];
    int errors = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit hold_receiver = 0;

    task automatic queue_beat(input t_beat b);
        pending_beats = {pending_beats, b};
    endtask

    function automatic t_beat take_beat();
        t_beat b;
        b = pending_beats[0];
        pending_beats.delete(0);
        return b;
    endfunction

    // Predicts every beat an order causes and updates the book model.
    task automatic match_order(input logic [1:0] side, input logic [PW-1:0] price,
                               input logic [QW-1:0] qty);
        logic [31:0] oid;
        logic [QW-1:0] t;
        bit buy;
        int pos;
        t_entry e;
        oid = next_order_id;
        next_order_id++;
        if (side != SIDE_BUY && side != SIDE_SELL) begin
            queue_beat('{KIND_BAD, oid, 0, 0, 0, 0, 1'b1});
            return;
        end
        buy = (side == SIDE_BUY);
        if (buy) begin
            while (qty != 0 && asks.size() > 0 && price >= asks[0].price) begin
                t = (qty < asks[0].qty) ? qty : asks[0].qty;
                queue_beat('{KIND_FILL, oid, asks[0].id, next_trade_id,
                             asks[0].price, t, 1'b0});
                next_trade_id++;
                qty -= t;
                asks[0].qty -= t;
                if (asks[0].qty == 0) asks.delete(0);
            end
        end else begin
            while (qty != 0 && bids.size() > 0 && bids[0].price >= price) begin
                t = (qty < bids[0].qty) ? qty : bids[0].qty;
                queue_beat('{KIND_FILL, oid, bids[0].id, next_trade_id,
                             bids[0].price, t, 1'b0});
                next_trade_id++;
                qty -= t;
                bids[0].qty -= t;
                if (bids[0].qty == 0) bids.delete(0);
            end
        end
        if (qty == 0) begin
            queue_beat('{KIND_DONE, oid, 0, 0, 0, 0, 1'b1});
        end else if ((buy ? bids.size() : asks.size()) >= DEPTH) begin
            queue_beat('{KIND_FULL, oid, 0, 0, price, qty, 1'b1});
        end else begin
            e = '{price, qty, oid};
            pos = 0;
            if (buy) begin
                while (pos < bids.size() && bids[pos].price >= price) pos++;
                bids.insert(pos, e);
            end else begin
                while (pos < asks.size() && asks[pos].price <= price) pos++;
                asks.insert(pos, e);
            end
            queue_beat('{KIND_RESTED, oid, 0, 0, price, qty, 1'b1});
        end
    endtask

    // Valid stays high after a beat is taken; the next call either replaces the
    // payload at once or drops valid for the idle gap.
    task automatic send_order(input logic [1:0] side, input logic [PW-1:0] price,
                              input logic [QW-1:0] qty);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_side <= side;
        i_limit_price <= price;
        i_order_qty <= qty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        match_order(side, price, qty);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_beats.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver: after each beat it draws rx_wait at random and stalls until that count
    // runs out, or holds off for a long stretch when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_receiver) begin
            i_stall <= hold_receiver;
        end else if (o_valid && !i_stall) begin
            rx_wait = $urandom_range(0, 6);
            i_stall <= (rx_wait != 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= (rx_wait != 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        t_beat got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_kind, o_order_number, o_resting_number, o_trade_number,
                    o_fill_price, o_fill_qty, o_last};
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat %p", $time, got);
                errors++;
            end else begin
                want = take_beat();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_order(SIDE_BUY, 16'd100, 20'd10);
        send_order(SIDE_SELL, 16'd101, 20'd5);
        send_order(SIDE_SELL, 16'd90, 20'd4);
        send_order(SIDE_BUY, 16'd200, 20'd8);
        send_order(SIDE_BUY, 16'hFFFF, 20'hFFFFF);
        send_order(SIDE_SELL, 16'd0, 20'hFFFFF);
        send_order(SIDE_SELL, 16'd0, 20'hFFFFF);
        send_order(2'd2, 16'hFFFF, 20'hFFFFF);
        send_order(2'd3, 16'd5, 20'd5);
        send_order(SIDE_BUY, 16'd50, 20'd0);
        send_order(SIDE_SELL, 16'hFFFF, 20'd0);
        wait_drained();
    endtask

    // Fills the ask book, overflows it, then sweeps it with one buy of many fills.
    task automatic test_full_book_and_sweep();
        int k;
        for (k = 0; k < DEPTH + 3; k++)
            send_order(SIDE_SELL, 16'(1000 + $urandom_range(0, 7)), 20'($urandom_range(1, 3)));
        send_order(SIDE_BUY, 16'hFFFF, 20'hFFFFF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        hold_receiver = 1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                hold_receiver = 0;
            end
            for (k = 0; k < 6; k++)
                send_order(2'($urandom_range(0, 1)), 16'($urandom_range(95, 105)),
                           20'($urandom_range(1, 20)));
        join
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int k;
        logic [1:0] side;
        logic [PW-1:0] price;
        logic [QW-1:0] qty;
        for (k = 0; k < count; k++) begin
            side = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1));
            price = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(490, 510));
            case ($urandom_range(0, 9))
                0: qty = 20'($urandom);
                1: qty = '0;
                default: qty = 20'($urandom_range(1, 50));
            endcase
            send_order(side, price, qty);
            if (k % 80 == 79) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        next_order_id = 32'd1;
        next_trade_id = 32'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_book_and_sweep();
        test_backpressure();
        test_random(260);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
